/* rtl/lkvc_pkg.sv */
// Package for the LRU key-value cache: shared types and constants.
// Used by the channel interfaces, the cell and the top level.
package lkvc_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 32;
  localparam int unsigned CapW = 5;

  localparam logic [CapW-1:0] CAP_RESET = 5'd16;

  // Operation codes carried in func
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  // One stored entry
  typedef struct packed {
    logic                   valid;
    logic signed [KeyW-1:0] key;
    logic signed [ValW-1:0] value;
  } entry_t;

  // Per-cell control from the top level
  typedef struct packed {
    logic clear;  // drop the entry (store flush)
    logic take;   // load the neighbor's entry
  } cell_ctrl_t;

endpackage

/* rtl/lkvc_req_if.sv */
// Request channel interface: get/put operations into the cache.
// Depends on lkvc_pkg for field widths.
interface lkvc_req_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic signed [lkvc_pkg::KeyW-1:0]  key;
  logic signed [lkvc_pkg::ValW-1:0]  value;

  modport source (output valid, func, key, value, input ready);
  modport sink   (input valid, func, key, value, output ready);
endinterface

/* rtl/lkvc_rsp_if.sv */
// Response channel interface: one result per request transaction.
// Depends on lkvc_pkg for field widths.
interface lkvc_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic signed [lkvc_pkg::ValW-1:0]  read_value;
  logic                              evicted;
  logic signed [lkvc_pkg::KeyW-1:0]  evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

/* rtl/lkvc_cfg_if.sv */
// Configuration write channel interface: the capacity register.
// Depends on lkvc_pkg for the register width.
interface lkvc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lkvc_pkg::CapW-1:0]  capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

/* rtl/lkvc_cell.sv */
// One recency cell of the LRU chain: holds an entry, compares its key,
// and loads its younger neighbor's entry when the chain shifts. Uses lkvc_pkg.
module lkvc_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lkvc_pkg::cell_ctrl_t             ctrl_i,
  input  lkvc_pkg::entry_t                 nbr_i,
  input  logic signed [lkvc_pkg::KeyW-1:0] cmp_key_i,
  output lkvc_pkg::entry_t                 ent_o,
  output logic                             match_o
);

  logic                              valid_q, valid_d;
  logic signed [lkvc_pkg::KeyW-1:0]  key_q;
  logic signed [lkvc_pkg::ValW-1:0]  value_q;

  // Valid bit: flush wins over shift
  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.take) begin
      valid_d = nbr_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take && !ctrl_i.clear) begin
      key_q   <= nbr_i.key;
      value_q <= nbr_i.value;
    end
  end

  assign match_o = valid_q && (key_q == cmp_key_i);
  assign ent_o   = '{valid: valid_q, key: key_q, value: value_q};

endmodule

/* rtl/lru_key_value_cache.sv */
// Top level of the LRU key-value cache: a chain of recency cells, the
// capacity register and the response register. Uses lkvc_pkg, lkvc_cell, interfaces.
//
//   channel | dir | payload                                   | transaction when
//   req     | in  | func, key, value                          | req.valid && req.ready
//   rsp     | out | hit, read_value, evicted, evicted_key     | rsp.valid && rsp.ready
//   cfg     | in  | capacity                                  | cfg.valid && cfg.ready
//
// Cell position is recency: cell 0 is most recent, cell occupancy-1 the least.
// One request per cycle while rsp is not stalled: lookup, shift of the chain and
// result register all complete in the accept cycle; the result appears in the next cycle.
// Reset empties the store and sets capacity to 16; a capacity write also
// empties it. cfg is always ready.
// A stalled rsp holds its result; req is then ready only as rsp drains.
module lru_key_value_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lkvc_req_if.sink    req,
  lkvc_rsp_if.source  rsp,
  lkvc_cfg_if.sink    cfg
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  logic [lkvc_pkg::CapW-1:0] cap_q;
  logic [CntW-1:0]           occ_q, occ_d;
  logic [CntW-1:0]           lim;
  logic [CntW-1:0]           bound;

  lkvc_pkg::entry_t     ent   [ENTRIES];
  lkvc_pkg::entry_t     nbr   [ENTRIES];
  lkvc_pkg::cell_ctrl_t ctrl  [ENTRIES];
  logic [ENTRIES-1:0]   match;
  logic [ENTRIES-1:0]   match_above;   // a match at this cell or an older one
  logic [ENTRIES-1:0]   valid_vec;
  logic [ENTRIES-1:0]   tail_sel;

  logic                              req_acc, cfg_acc;
  logic                              any_hit, is_put, full, update;
  logic signed [lkvc_pkg::ValW-1:0]  hit_value;
  logic signed [lkvc_pkg::KeyW-1:0]  tail_key;
  lkvc_pkg::entry_t                  head_ent;

  logic                              rsp_valid_q;
  logic                              hit_q, evicted_q;
  logic signed [lkvc_pkg::ValW-1:0]  read_value_q;
  logic signed [lkvc_pkg::KeyW-1:0]  evicted_key_q;

  assign cfg.ready = 1'b1;
  assign cfg_acc   = cfg.valid && cfg.ready;
  assign req.ready = !rsp_valid_q || rsp.ready;
  assign req_acc   = req.valid && req.ready;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CAP_RESET;
    end else if (cfg_acc) begin
      cap_q <= cfg.capacity;
    end
  end

  // Effective limit: zero acts as one, saturate at the cell count
  always_comb begin
    if (cap_q == '0) begin
      lim = CntW'(1);
    end else if (32'(cap_q) > ENTRIES) begin
      lim = CntW'(ENTRIES);
    end else begin
      lim = CntW'(cap_q);
    end
  end

  // Cell chain
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign nbr[i] = head_ent;
    end else begin : g_body
      assign nbr[i] = ent[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign match_above[i] = match[i];
    end else begin : g_mid
      assign match_above[i] = match[i] || match_above[i+1];
    end

    assign valid_vec[i] = ent[i].valid;
    assign tail_sel[i]  = (occ_q == CntW'(i + 1));
    assign ctrl[i].clear = cfg_acc;
    assign ctrl[i].take  = update &&
                           (any_hit ? match_above[i] : (CntW'(i) <= bound));

    lkvc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl[i]),
      .nbr_i     (nbr[i]),
      .cmp_key_i (req.key),
      .ent_o     (ent[i]),
      .match_o   (match[i])
    );
  end

  // Matched value and tail key by and-or selection
  always_comb begin
    hit_value = '0;
    tail_key  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | (ent[i].value & {lkvc_pkg::ValW{match[i]}});
      tail_key  = tail_key  | (ent[i].key   & {lkvc_pkg::KeyW{tail_sel[i]}});
    end
  end

  assign any_hit = |match;
  assign is_put  = (req.func == lkvc_pkg::FUNC_PUT);
  assign full    = (occ_q >= lim);
  assign update  = req_acc && (any_hit || is_put);
  // Oldest cell that shifts on a miss insert: the tail when full, else the free cell
  assign bound   = full ? (occ_q - CntW'(1)) : occ_q;

  // New head entry: fresh value on put, kept value on get hit
  always_comb begin
    head_ent.valid = 1'b1;
    head_ent.key   = req.key;
    head_ent.value = is_put ? req.value : hit_value;
  end

  // Occupancy
  always_comb begin
    occ_d = occ_q;
    if (cfg_acc) begin
      occ_d = '0;
    end else if (req_acc && is_put && !any_hit && !full) begin
      occ_d = occ_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_acc) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      hit_q         <= any_hit;
      read_value_q  <= (!is_put && any_hit) ? hit_value : '0;
      evicted_q     <= is_put && !any_hit && full;
      evicted_key_q <= (is_put && !any_hit && full) ? tail_key : '0;
    end
  end

  assign rsp.valid       = rsp_valid_q;
  assign rsp.hit         = hit_q;
  assign rsp.read_value  = read_value_q;
  assign rsp.evicted     = evicted_q;
  assign rsp.evicted_key = evicted_key_q;

  // Checks
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_q) <= ENTRIES)
    else $error("occupancy above cell count");

  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(occ_q))
    else $error("valid cells disagree with occupancy");

  a_unique_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("key present in more than one cell");

  a_cfg_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_acc |=> (occ_q == '0) && (valid_vec == '0))
    else $error("store not empty after capacity write");

  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.evicted |-> !rsp.hit)
    else $error("eviction reported on a hit");

endmodule

/* tb/lru_key_value_cache_tb.sv */
// Self-checking testbench for lru_key_value_cache: directed table, then random get/put.
// Depends on lkvc_pkg, the req/rsp/cfg channel interfaces and the cache top level.
module lru_key_value_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 175;
  localparam int POOL_MAX    = 24;

  // Row kinds of the directed table and whether a row carries a typed result
  localparam logic ROW_OP  = 1'b0;
  localparam logic ROW_CFG = 1'b1;
  localparam logic PINNED  = 1'b1;
  localparam logic PREDICT = 1'b0;

  // Sender / receiver idling modes
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } lru_result_t;

  localparam lru_result_t ZERO_RESULT = '0;

  typedef struct packed {
    logic        is_cfg;
    logic        func;
    logic [31:0] key;
    logic [31:0] data;   // put value, or capacity on a config row
    logic        pin;
    lru_result_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  lkvc_req_if req_ch ();
  lkvc_rsp_if rsp_ch ();
  lkvc_cfg_if cfg_ch ();

  lru_key_value_cache #(.ENTRIES(SLOTS)) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req   (req_ch),
    .rsp   (rsp_ch),
    .cfg   (cfg_ch)
  );

  // Typed expectation traveling alongside the request payload
  logic        row_pinned;
  lru_result_t row_want;

  // Recency model state
  logic        slot_used [SLOTS];
  logic [31:0] slot_key  [SLOTS];
  logic [31:0] slot_val  [SLOTS];
  int unsigned slot_age  [SLOTS];
  int unsigned fill;
  logic [4:0]  cap_model;

  lru_result_t pending_q[$];

  int unsigned rx_stall_pct;
  int unsigned tx_idle_pct;
  int unsigned hold_len;
  int unsigned hold_ticket;
  int unsigned cycles;
  int unsigned fails;
  int unsigned n_items, n_hits, n_evicts, n_cfg;

  // Directed stimulus: extremes, update, miss, tiny and saturated capacity
  dir_row_t dir_tab [24] = '{
    '{ROW_OP,  lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'h1234_5678, PINNED,  ZERO_RESULT},
    '{ROW_OP,  lkvc_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000, PINNED,  ZERO_RESULT},
    '{ROW_OP,  lkvc_pkg::FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF, PINNED,  ZERO_RESULT},
    '{ROW_OP,  lkvc_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000, PINNED,
      '{1'b1, 32'h8000_0000, 1'b0, 32'h0}},
    '{ROW_OP,  lkvc_pkg::FUNC_GET, 32'h8000_0000, 32'hFFFF_FFFF, PINNED,
      '{1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0}},
    '{ROW_OP,  lkvc_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PINNED,  ZERO_RESULT},
    '{ROW_OP,  lkvc_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h0000_0000, PINNED,
      '{1'b1, 32'h0, 1'b0, 32'h0}},
    '{ROW_OP,  lkvc_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h5555_5555, PINNED,
      '{1'b1, 32'h0, 1'b0, 32'h0}},
    '{ROW_OP,  lkvc_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000, PINNED,
      '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
    '{ROW_CFG, lkvc_pkg::FUNC_GET, 32'h0,         32'd1,         PREDICT, ZERO_RESULT},
    '{ROW_OP,  lkvc_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000, PINNED,  ZERO_RESULT},
    '{ROW_OP,  lkvc_pkg::FUNC_PUT, 32'h0000_0001, 32'hAAAA_AAAA, PINNED,  ZERO_RESULT},
    '{ROW_OP,  lkvc_pkg::FUNC_PUT, 32'h0000_0002, 32'h5555_5555, PINNED,
      '{1'b0, 32'h0, 1'b1, 32'h1}},
    '{ROW_OP,  lkvc_pkg::FUNC_PUT, 32'h0000_0002, 32'h0000_0001, PINNED,
      '{1'b1, 32'h0, 1'b0, 32'h0}},
    '{ROW_OP,  lkvc_pkg::FUNC_GET, 32'h0000_0001, 32'h0000_0000, PINNED,  ZERO_RESULT},
    '{ROW_CFG, lkvc_pkg::FUNC_GET, 32'h0,         32'd0,         PREDICT, ZERO_RESULT},
    '{ROW_OP,  lkvc_pkg::FUNC_PUT, 32'h0000_0003, 32'h0000_0003, PINNED,  ZERO_RESULT},
    '{ROW_OP,  lkvc_pkg::FUNC_PUT, 32'h0000_0004, 32'h0000_0004, PINNED,
      '{1'b0, 32'h0, 1'b1, 32'h3}},
    '{ROW_CFG, lkvc_pkg::FUNC_GET, 32'h0,         32'd2,         PREDICT, ZERO_RESULT},
    '{ROW_OP,  lkvc_pkg::FUNC_PUT, 32'h0000_0005, 32'h0000_0005, PREDICT, ZERO_RESULT},
    '{ROW_OP,  lkvc_pkg::FUNC_PUT, 32'h0000_0006, 32'h0000_0006, PREDICT, ZERO_RESULT},
    '{ROW_OP,  lkvc_pkg::FUNC_GET, 32'h0000_0005, 32'h0000_0000, PREDICT, ZERO_RESULT},
    '{ROW_OP,  lkvc_pkg::FUNC_PUT, 32'h0000_0007, 32'h0000_0007, PREDICT, ZERO_RESULT},
    '{ROW_CFG, lkvc_pkg::FUNC_GET, 32'h0,         32'd31,        PREDICT, ZERO_RESULT}
  };

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Capacity seen by the model: zero acts as one, above SLOTS saturates
  function automatic int unsigned cap_limit();
    if (cap_model == 5'd0) return 1;
    if (cap_model > SLOTS) return SLOTS;
    return cap_model;
  endfunction

  function automatic void store_clear();
    int i;
    for (i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
    fill = 0;
  endfunction

  // One get or put against the recency model; returns the expected result
  function automatic lru_result_t lru_access(logic f, logic [31:0] k, logic [31:0] v);
    lru_result_t r;
    int i, found, slot;
    int unsigned oldest, prior;
    r = '0;
    found = -1;
    slot = -1;
    oldest = 0;
    for (i = 0; i < SLOTS; i++) begin
      if (found < 0 && slot_used[i] && slot_key[i] == k) found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      if (f == lkvc_pkg::FUNC_GET) r.read_value = slot_val[found];
      else slot_val[found] = v;
      // promote: younger entries age by one
      prior = slot_age[found];
      for (i = 0; i < SLOTS; i++) begin
        if (slot_used[i] && i != found && slot_age[i] < prior) slot_age[i]++;
      end
      slot_age[found] = 0;
    end else if (f == lkvc_pkg::FUNC_PUT) begin
      if (fill >= cap_limit()) begin
        for (i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && (slot < 0 || slot_age[i] > oldest)) begin
            slot = i;
            oldest = slot_age[i];
          end
        end
        if (slot >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = slot_key[slot];
          slot_used[slot] = 1'b0;
          fill--;
        end
      end
      if (slot < 0) begin
        for (i = SLOTS - 1; i >= 0; i--) begin
          if (!slot_used[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        for (i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && i != slot) slot_age[i]++;
        end
        slot_used[slot] = 1'b1;
        slot_key[slot]  = k;
        slot_val[slot]  = v;
        slot_age[slot]  = 0;
        fill++;
      end
    end
    return r;
  endfunction

  // Monitor: check results, then track config and request transactions
  always @(posedge clk) begin
    lru_result_t want, got;
    if (rst_n) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.hit, rsp_ch.read_value, rsp_ch.evicted, rsp_ch.evicted_key};
        if (pending_q.size() == 0) begin
          $error("unexpected response transaction: hit %0d read_value %h", got.hit,
                 got.read_value);
          fails++;
        end else begin
          want = pending_q.pop_front();
          if (got.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
            fails++;
          end
          if (got.read_value !== want.read_value) begin
            $error("read_value: expected %h, actual %h", want.read_value, got.read_value);
            fails++;
          end
          if (got.evicted !== want.evicted) begin
            $error("evicted: expected %0d, actual %0d", want.evicted, got.evicted);
            fails++;
          end
          if (got.evicted_key !== want.evicted_key) begin
            $error("evicted_key: expected %h, actual %h", want.evicted_key, got.evicted_key);
            fails++;
          end
        end
        if (got.hit === 1'b1) n_hits++;
        if (got.evicted === 1'b1) n_evicts++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        cap_model = cfg_ch.capacity;
        store_clear();
        n_cfg++;
      end
      if (req_ch.valid && req_ch.ready) begin
        want = lru_access(req_ch.func, req_ch.key, req_ch.value);
        if (row_pinned) want = row_want;
        pending_q.push_back(want);
        n_items++;
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Response side: random stalls, plus long hold-offs on request
  initial begin
    int unsigned hold_taken, hold_left;
    hold_taken = 0;
    hold_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ticket != hold_taken) begin
        hold_left = hold_len;
        hold_taken = hold_ticket;
      end
      if (!rst_n) begin
        rsp_ch.ready = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready = 1'b0;
      end else begin
        rsp_ch.ready = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Offer one request, idling first at the sender's rate; returns on accept
  task automatic send_op(logic f, logic [31:0] k, logic [31:0] v, logic pin,
                         lru_result_t want);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.func  = f;
    req_ch.key   = k;
    req_ch.value = v;
    row_pinned   = pin;
    row_want     = want;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Stop offering and wait until every expected result has arrived
  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Capacity write, only with the cache idle
  task automatic write_capacity(logic [4:0] cap);
    drain();
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid    = 1'b1;
    cfg_ch.capacity = cap;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_idle(idle_mode_e m);
    case (m)
      IDLE_NONE:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      IDLE_SENDER:   begin tx_idle_pct = 58; rx_stall_pct = 0;  end
      IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 58; end
      default:       begin tx_idle_pct = 7;  rx_stall_pct = 7;  end
    endcase
  endtask

  // Main stimulus
  initial begin
    logic [4:0]  phase_caps [8];
    logic [31:0] pool [POOL_MAX];
    logic [31:0] k;
    logic [4:0]  cap;
    int          p, n, i, pool_n, eff;
    phase_caps = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd17, 5'd2, 5'd12, 5'd31};

    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.func  = lkvc_pkg::FUNC_GET;
    req_ch.key   = '0;
    req_ch.value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.capacity = '0;
    row_pinned = PREDICT;
    row_want   = ZERO_RESULT;
    hold_len = 0;
    hold_ticket = 0;
    cycles = 0;
    fails = 0;
    n_items = 0;
    n_hits = 0;
    n_evicts = 0;
    n_cfg = 0;
    cap_model = lkvc_pkg::CAP_RESET;
    store_clear();
    set_idle(IDLE_NONE);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table
    for (i = 0; i < 24; i++) begin
      if (dir_tab[i].is_cfg == ROW_CFG) write_capacity(dir_tab[i].data[4:0]);
      else send_op(dir_tab[i].func, dir_tab[i].key, dir_tab[i].data, dir_tab[i].pin,
                   dir_tab[i].want);
    end

    // Random phases: each its own capacity, idling mode and key pool
    for (p = 0; p < 8; p++) begin
      cap = (p == 7) ? 5'($urandom_range(31)) : phase_caps[p];
      write_capacity(cap);
      set_idle(idle_mode_e'(p % 4));
      eff = (cap == 0) ? 1 : (cap > SLOTS) ? SLOTS : cap;
      pool_n = eff + $urandom_range(1, 6);
      if (pool_n > POOL_MAX) pool_n = POOL_MAX;
      for (i = 0; i < pool_n; i++) begin
        case ($urandom_range(11))
          0:       pool[i] = 32'h0000_0000;
          1:       pool[i] = 32'hFFFF_FFFF;
          2:       pool[i] = 32'h8000_0000;
          3:       pool[i] = 32'h7FFF_FFFF;
          default: pool[i] = $urandom;
        endcase
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // long response hold-off while requests keep coming
        if (p == 0 && n == 60) begin
          hold_len = 200;
          hold_ticket++;
        end
        if (p == 2 && n == 80) drain();
        k = ($urandom_range(9) == 0) ? 32'($urandom) : pool[$urandom_range(pool_n - 1)];
        send_op(logic'($urandom_range(1)), k, $urandom, PREDICT, ZERO_RESULT);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Ran %0d get/put transactions across %0d capacity writes (extremes included).",
             n_items, n_cfg);
    $display("Observed %0d hits and %0d evictions; %0d mismatches.", n_hits, n_evicts,
             fails);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
